// File: design/erfp_pkg.sv
// ----------------------------------------------------------------------------
// erfp_pkg
// Shared types and constants of the escaped record field parser.
// ----------------------------------------------------------------------------
package erfp_pkg;

	localparam int FIELD_COUNT = 9;
	localparam int FIELD_W     = 4;

	localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(FIELD_COUNT - 1);
	localparam logic [FIELD_W-1:0] OVER_FIELD = FIELD_W'(FIELD_COUNT);
	localparam logic [FIELD_W-1:0] TYPE_FIELD = FIELD_W'(0);
	localparam logic [FIELD_W-1:0] SEQ_FIELD  = FIELD_W'(7);

	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FIELD_COUNT = 3'd1,
		ST_TYPE_NODIG  = 3'd2,
		ST_TYPE_RANGE  = 3'd3,
		ST_SEQ_NODIG   = 3'd4,
		ST_SEQ_RANGE   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_NODIG = 2'd1,
		ERR_RANGE = 2'd2
	} num_err_t;

	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} num_phase_t;

	// classified item handed from the front end to the back end
	typedef struct packed {
		logic [7:0]         chr;
		logic               last;
		logic               delim;
		logic               num_feed;
		logic               is_type;
		logic               is_seq;
		logic               count_ok;
		logic               byte_valid;
		logic [FIELD_W-1:0] field_number;
	} q_item_t;

endpackage

// File: design/erfp_if.sv
// ----------------------------------------------------------------------------
// erfp_if
// Valid/ready channels of the parser: raw record bytes in, results out.
// ----------------------------------------------------------------------------
interface erfp_rec_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface erfp_res_if;
	logic               valid;
	logic               ready;
	logic               byte_valid;
	logic [7:0]         data_byte;
	logic [3:0]         field_number;
	logic               field_end;
	logic               record_end;
	logic [2:0]         status;
	logic signed [31:0] packet_type;
	logic [63:0]        sequence_number;

	modport source (
		output valid, output byte_valid, output data_byte, output field_number,
		output field_end, output record_end, output status, output packet_type,
		output sequence_number, input ready
	);
	modport sink (
		input valid, input byte_valid, input data_byte, input field_number,
		input field_end, input record_end, input status, input packet_type,
		input sequence_number, output ready
	);
endinterface

// File: design/escaped_record_field_parser_unit.sv
// ----------------------------------------------------------------------------
// escaped_record_field_parser_unit
// Splits a pipe-delimited, backslash-escaped record into fields.
// ----------------------------------------------------------------------------
// One byte is taken per clock and every byte gives one result item, so the
// rate is one item per cycle unless the output stalls; each byte is queued,
// then registered in stage 1 and the output stage. The rate is set by the
// per-byte times-ten accumulate of the decimal fields in the back end, which
// is decoupled from the byte classifier by a two-entry queue and followed by a
// field-finish stage and the output register. String field bytes come out
// unescaped with their field number; field 0 (signed 32-bit) and field 7
// (unsigned 64-bit) are parsed and given, with the status, on the last byte.
module escaped_record_field_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	erfp_rec_if.sink   rec,
	erfp_res_if.source res
);

	logic              push;
	logic              full;
	logic              pop;
	logic              not_empty;
	erfp_pkg::q_item_t wr_item;
	erfp_pkg::q_item_t rd_item;

	erfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec),
		.full   (full),
		.push   (push),
		.item   (wr_item)
	);

	erfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (wr_item),
		.full      (full),
		.pop       (pop),
		.rd_item   (rd_item),
		.not_empty (not_empty)
	);

	erfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_item   (rd_item),
		.not_empty (not_empty),
		.pop       (pop),
		.res       (res)
	);

endmodule

// File: design/erfp_front.sv
// ----------------------------------------------------------------------------
// erfp_front
// Accepts raw bytes, resolves escapes and pipes, tracks the field index.
// ----------------------------------------------------------------------------
module erfp_front (
	input  logic              clk,
	input  logic              arst_n,
	erfp_rec_if.sink          rec,
	input  logic              full,
	output logic              push,
	output erfp_pkg::q_item_t item
);

	logic                        esc_q;
	logic [erfp_pkg::FIELD_W-1:0] fi_q;
	logic [erfp_pkg::FIELD_W-1:0] fi_next;
	logic                        esc_next;
	logic                        content;
	logic                        emit;
	logic                        delim;
	logic                        is_type;
	logic                        is_seq;
	logic                        stringf;

	assign rec.ready = !full;
	assign push      = rec.valid && !full;

	always_comb begin
		content  = 1'b0;
		emit     = 1'b0;
		delim    = 1'b0;
		esc_next = 1'b0;
		if (esc_q) begin
			content = 1'b1;
			emit    = 1'b1;
		end else if (rec.in_byte == erfp_pkg::CH_BSLASH) begin
			content  = 1'b1;
			esc_next = 1'b1;
		end else if (rec.in_byte == erfp_pkg::CH_PIPE) begin
			delim = 1'b1;
		end else begin
			content = 1'b1;
			emit    = 1'b1;
		end

		is_type = (fi_q == erfp_pkg::TYPE_FIELD);
		is_seq  = (fi_q == erfp_pkg::SEQ_FIELD);
		stringf = (fi_q < erfp_pkg::OVER_FIELD) && !is_type && !is_seq;

		fi_next = fi_q;
		if (delim && fi_q < erfp_pkg::OVER_FIELD) begin
			fi_next = fi_q + erfp_pkg::FIELD_W'(1);
		end

		item.chr          = rec.in_byte;
		item.last         = rec.last;
		item.delim        = delim;
		item.num_feed     = content && (is_type || is_seq);
		item.is_type      = is_type;
		item.is_seq       = is_seq;
		item.count_ok     = (fi_next == erfp_pkg::LAST_FIELD);
		item.byte_valid   = emit && stringf;
		item.field_number = (fi_q > erfp_pkg::LAST_FIELD) ? erfp_pkg::LAST_FIELD : fi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			fi_q  <= '0;
		end else if (push) begin
			if (rec.last) begin
				esc_q <= 1'b0;
				fi_q  <= '0;
			end else begin
				esc_q <= esc_next;
				fi_q  <= fi_next;
			end
		end
	end

endmodule

// File: design/erfp_queue.sv
// ----------------------------------------------------------------------------
// erfp_queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module erfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  erfp_pkg::q_item_t wr_item,
	output logic              full,
	input  logic              pop,
	output erfp_pkg::q_item_t rd_item,
	output logic              not_empty
);

	erfp_pkg::q_item_t              slot_q [erfp_pkg::QDEPTH];
	logic [erfp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [erfp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [erfp_pkg::QCNT_W-1:0]    count_q;

	assign full      = (count_q == erfp_pkg::QCNT_W'(erfp_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == erfp_pkg::QPTR_W'(erfp_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + erfp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == erfp_pkg::QPTR_W'(erfp_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + erfp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + erfp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - erfp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// File: design/erfp_back.sv
// ----------------------------------------------------------------------------
// erfp_back
// Decimal accumulation (stage 1), field finishing and status (stage 2).
// ----------------------------------------------------------------------------
module erfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  erfp_pkg::q_item_t rd_item,
	input  logic              not_empty,
	output logic              pop,
	erfp_res_if.source        res
);

	// number accumulator
	erfp_pkg::num_phase_t ph_q;
	logic                 neg_q;
	logic [63:0]          mag_q;
	logic                 ovf_q;

	// stage 1
	logic                         valid_s1;
	logic                         fin_s1;
	logic                         is_type_s1;
	logic                         is_seq_s1;
	logic                         nodig_s1;
	logic                         neg_s1;
	logic [63:0]                  mag_s1;
	logic                         ovf_s1;
	logic                         last_s1;
	logic                         count_ok_s1;
	logic                         byte_valid_s1;
	logic [7:0]                   data_s1;
	logic [erfp_pkg::FIELD_W-1:0] field_number_s1;
	logic                         field_end_s1;

	// per-record results
	logic [31:0]        t_res_q;
	erfp_pkg::num_err_t t_err_q;
	logic [63:0]        s_res_q;
	erfp_pkg::num_err_t s_err_q;

	// stage 2 (output register)
	logic                         valid_s2;
	logic                         byte_valid_s2;
	logic [7:0]                   data_s2;
	logic [erfp_pkg::FIELD_W-1:0] field_number_s2;
	logic                         field_end_s2;
	logic                         record_end_s2;
	erfp_pkg::status_t            status_s2;
	logic [31:0]                  ptype_s2;
	logic [63:0]                  seq_s2;

	logic adv2;
	logic adv1;

	// stage 1 combinational
	logic                 digit;
	logic                 space;
	logic                 sign;
	logic [3:0]           dval;
	logic [67:0]          prod;
	logic                 active;
	logic                 term;
	logic                 fin;
	logic                 close;
	erfp_pkg::num_phase_t ph_f;
	logic                 neg_f;
	logic [63:0]          mag_f;
	logic                 ovf_f;

	// stage 2 combinational
	logic               t_over;
	logic [31:0]        t_val;
	logic [63:0]        s_val;
	logic [31:0]        t_res_n;
	erfp_pkg::num_err_t t_err_n;
	logic [63:0]        s_res_n;
	erfp_pkg::num_err_t s_err_n;
	erfp_pkg::status_t  st;

	assign adv2 = !valid_s2 || res.ready;
	assign adv1 = !valid_s1 || adv2;
	assign pop  = not_empty && adv1;

	always_comb begin
		digit  = (rd_item.chr >= erfp_pkg::CH_ZERO) && (rd_item.chr <= erfp_pkg::CH_NINE);
		space  = (rd_item.chr == erfp_pkg::CH_SPACE) ||
			((rd_item.chr >= erfp_pkg::CH_TAB) && (rd_item.chr <= erfp_pkg::CH_CR));
		sign   = (rd_item.chr == erfp_pkg::CH_PLUS) || (rd_item.chr == erfp_pkg::CH_MINUS);
		dval   = 4'(rd_item.chr - erfp_pkg::CH_ZERO);
		// mag * 10 + digit; anything above bit 63 is an overflow
		prod   = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {64'd0, dval};
		active = rd_item.num_feed && (ph_q != erfp_pkg::PH_DONE);
		term   = 1'b0;
		ph_f   = ph_q;
		neg_f  = neg_q;
		mag_f  = mag_q;
		ovf_f  = ovf_q;
		if (active) begin
			if (digit) begin
				ph_f = erfp_pkg::PH_DIGITS;
				if (!ovf_q) begin
					if (prod[67:64] != 4'd0) begin
						ovf_f = 1'b1;
					end else begin
						mag_f = prod[63:0];
					end
				end
			end else if (ph_q == erfp_pkg::PH_SKIP && space) begin
				ph_f = ph_q;
			end else if (ph_q == erfp_pkg::PH_SKIP && sign) begin
				neg_f = (rd_item.chr == erfp_pkg::CH_MINUS);
				ph_f  = erfp_pkg::PH_SIGN;
			end else begin
				term = 1'b1;
			end
		end
		close = rd_item.delim || rd_item.last;
		fin   = (rd_item.is_type || rd_item.is_seq) && (ph_f != erfp_pkg::PH_DONE) &&
			(term || close);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= erfp_pkg::PH_SKIP;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= not_empty;
			end
			if (pop) begin
				if (close) begin
					ph_q  <= erfp_pkg::PH_SKIP;
					neg_q <= 1'b0;
					mag_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					ph_q  <= fin ? erfp_pkg::PH_DONE : ph_f;
					neg_q <= neg_f;
					mag_q <= mag_f;
					ovf_q <= ovf_f;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fin_s1          <= fin;
			is_type_s1      <= rd_item.is_type;
			is_seq_s1       <= rd_item.is_seq;
			nodig_s1        <= (ph_f != erfp_pkg::PH_DIGITS);
			neg_s1          <= neg_f;
			mag_s1          <= mag_f;
			ovf_s1          <= ovf_f;
			last_s1         <= rd_item.last;
			count_ok_s1     <= rd_item.count_ok;
			byte_valid_s1   <= rd_item.byte_valid;
			data_s1         <= rd_item.byte_valid ? rd_item.chr : 8'h00;
			field_number_s1 <= rd_item.field_number;
			field_end_s1    <= close;
		end
	end

	always_comb begin
		// int32 range: up to 2^31 when negative, 2^31-1 otherwise
		t_over = ovf_s1 || (neg_s1 ?
			((mag_s1[63:32] != 32'd0) || (mag_s1[31] && (mag_s1[30:0] != 31'd0))) :
			(mag_s1[63:31] != 33'd0));
		t_val  = neg_s1 ? (~mag_s1[31:0] + 32'd1) : mag_s1[31:0];
		s_val  = neg_s1 ? (~mag_s1 + 64'd1) : mag_s1;

		t_res_n = t_res_q;
		t_err_n = t_err_q;
		s_res_n = s_res_q;
		s_err_n = s_err_q;
		if (fin_s1 && is_type_s1) begin
			if (nodig_s1) begin
				t_err_n = erfp_pkg::ERR_NODIG;
			end else if (t_over) begin
				t_err_n = erfp_pkg::ERR_RANGE;
			end else begin
				t_res_n = t_val;
			end
		end
		if (fin_s1 && is_seq_s1) begin
			if (nodig_s1) begin
				s_err_n = erfp_pkg::ERR_NODIG;
			end else if (ovf_s1) begin
				s_err_n = erfp_pkg::ERR_RANGE;
			end else begin
				s_res_n = s_val;
			end
		end

		st = erfp_pkg::ST_OK;
		if (!count_ok_s1) begin
			st = erfp_pkg::ST_FIELD_COUNT;
		end else begin
			case (t_err_n)
				erfp_pkg::ERR_NODIG: st = erfp_pkg::ST_TYPE_NODIG;
				erfp_pkg::ERR_RANGE: st = erfp_pkg::ST_TYPE_RANGE;
				default: begin
					case (s_err_n)
						erfp_pkg::ERR_NODIG: st = erfp_pkg::ST_SEQ_NODIG;
						erfp_pkg::ERR_RANGE: st = erfp_pkg::ST_SEQ_RANGE;
						default:             st = erfp_pkg::ST_OK;
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_res_q  <= '0;
			t_err_q  <= erfp_pkg::ERR_NONE;
			s_res_q  <= '0;
			s_err_q  <= erfp_pkg::ERR_NONE;
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (last_s1) begin
					t_res_q <= '0;
					t_err_q <= erfp_pkg::ERR_NONE;
					s_res_q <= '0;
					s_err_q <= erfp_pkg::ERR_NONE;
				end else begin
					t_res_q <= t_res_n;
					t_err_q <= t_err_n;
					s_res_q <= s_res_n;
					s_err_q <= s_err_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			byte_valid_s2   <= byte_valid_s1;
			data_s2         <= data_s1;
			field_number_s2 <= field_number_s1;
			field_end_s2    <= field_end_s1;
			record_end_s2   <= last_s1;
			status_s2       <= last_s1 ? st : erfp_pkg::ST_OK;
			ptype_s2        <= (last_s1 && st == erfp_pkg::ST_OK) ? t_res_n : 32'd0;
			seq_s2          <= (last_s1 && st == erfp_pkg::ST_OK) ? s_res_n : 64'd0;
		end
	end

	assign res.valid           = valid_s2;
	assign res.byte_valid      = byte_valid_s2;
	assign res.data_byte       = data_s2;
	assign res.field_number    = field_number_s2;
	assign res.field_end       = field_end_s2;
	assign res.record_end      = record_end_s2;
	assign res.status          = status_s2;
	assign res.packet_type     = ptype_s2;
	assign res.sequence_number = seq_s2;

	a_err_zeroes_values: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != erfp_pkg::ST_OK) |-> (ptype_s2 == 32'd0 && seq_s2 == 64'd0))
		else $error("non-ok status with nonzero parsed values");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !record_end_s2) |-> (status_s2 == erfp_pkg::ST_OK && ptype_s2 == 32'd0))
		else $error("status or value outside record end");

	a_bytes_in_string_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && byte_valid_s2) |->
		(field_number_s2 != erfp_pkg::TYPE_FIELD && field_number_s2 != erfp_pkg::SEQ_FIELD))
		else $error("string byte tagged with a numeric field");

	a_acc_cleared_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (rd_item.delim || rd_item.last)) |=>
		(ph_q == erfp_pkg::PH_SKIP && mag_q == 64'd0 && !ovf_q && !neg_q))
		else $error("number accumulator not cleared at field close");

	a_record_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && valid_s1 && last_s1) |=>
		(t_err_q == erfp_pkg::ERR_NONE && s_err_q == erfp_pkg::ERR_NONE))
		else $error("record results not cleared after record end");

endmodule
